// ===== hdl/lsr_pkg.sv =====
`timescale 1ns / 1ps

package lsr_pkg;

    localparam int unsigned LSR_FIFO_DEPTH = 4;

    localparam logic [31:0] BREAK_MIN_RST = 32'd600000;
    localparam logic [7:0]  EXP_PID_RST   = 8'h3C;
    localparam logic [7:0]  SYNC_BYTE     = 8'h55;
    localparam logic [7:0]  BREAK_BYTE    = 8'h00;

    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_BREAK_MIN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXP_PID   = 1'd1;

    typedef enum logic [2:0] {
        KIND_FALL    = 3'd0,
        KIND_RISE    = 3'd1,
        KIND_BYTE    = 3'd2,
        KIND_RESPOND = 3'd3,
        KIND_SETTLE  = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        MODE_IDLE      = 2'd0,
        MODE_WAIT_SYNC = 2'd1,
        MODE_WAIT_PID  = 2'd2,
        MODE_RESP      = 2'd3
    } t_mode;

    typedef logic [2:0] t_bsel;
    localparam t_bsel SEL_BUTTONS = 3'd0;
    localparam t_bsel SEL_P1_HI   = 3'd1;
    localparam t_bsel SEL_P1_LO   = 3'd2;
    localparam t_bsel SEL_P2_HI   = 3'd3;
    localparam t_bsel SEL_P2_LO   = 3'd4;
    localparam t_bsel SEL_SUM     = 3'd5;

    typedef struct packed {
        logic [6:0]  buttons;
        logic [11:0] pot_one;
        logic [11:0] pot_two;
        logic [7:0]  sum;
    } t_resp;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [7:0] resp_byte(input t_resp r, input t_bsel sel);
        logic [7:0] b;
        case (sel)
            SEL_BUTTONS: b = {1'b0, r.buttons};
            SEL_P1_HI:   b = r.pot_one[11:4];
            SEL_P1_LO:   b = {r.pot_one[3:0], 4'h0};
            SEL_P2_HI:   b = r.pot_two[11:4];
            SEL_P2_LO:   b = {r.pot_two[3:0], 4'h0};
            SEL_SUM:     b = r.sum;
            default:     b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== hdl/lsr_front.sv =====
`timescale 1ns / 1ps

module lsr_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [2:0]                     i_kind,
    input  logic [31:0]                    i_line_time,
    input  logic [7:0]                     i_rx_byte,
    input  logic [6:0]                     i_buttons,
    input  logic [11:0]                    i_pot_one,
    input  logic [11:0]                    i_pot_two,
    input  logic                           i_cfg_valid,
    input  logic [lsr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [31:0]                    i_cfg_data,
    input  lsr_pkg::t_q_stat               i_q_stat,
    output logic                           o_push,
    output lsr_pkg::t_resp                 o_push_data
);

    lsr_pkg::t_mode r_mode, n_mode;
    logic [31:0]    r_fall_time;
    logic [31:0]    r_break_min;
    logic [7:0]     r_exp_pid;
    logic           acc;
    logic [31:0]    pulse;
    lsr_pkg::t_resp rec;

    assign o_in_stall = i_q_stat.full;
    assign acc        = i_in_valid && !i_q_stat.full;
    assign pulse      = i_line_time - r_fall_time;

    always_comb begin
        n_mode = r_mode;
        if (acc) begin
            case (lsr_pkg::t_kind'(i_kind))
                lsr_pkg::KIND_RISE: begin
                    if (r_mode != lsr_pkg::MODE_RESP && pulse >= r_break_min)
                        n_mode = lsr_pkg::MODE_WAIT_SYNC;
                end
                lsr_pkg::KIND_BYTE: begin
                    case (r_mode)
                        lsr_pkg::MODE_IDLE: begin
                            if (i_rx_byte == lsr_pkg::BREAK_BYTE)
                                n_mode = lsr_pkg::MODE_WAIT_SYNC;
                        end
                        lsr_pkg::MODE_WAIT_SYNC: begin
                            if (i_rx_byte == lsr_pkg::SYNC_BYTE)
                                n_mode = lsr_pkg::MODE_WAIT_PID;
                        end
                        lsr_pkg::MODE_WAIT_PID: begin
                            n_mode = (i_rx_byte == r_exp_pid) ? lsr_pkg::MODE_RESP
                                                              : lsr_pkg::MODE_IDLE;
                        end
                        default: n_mode = r_mode;
                    endcase
                end
                lsr_pkg::KIND_SETTLE: n_mode = lsr_pkg::MODE_IDLE;
                default: n_mode = r_mode;
            endcase
        end
    end

    always_comb begin
        rec.buttons = i_buttons;
        rec.pot_one = i_pot_one;
        rec.pot_two = i_pot_two;
        rec.sum     = 8'h00;
        rec.sum     = lsr_pkg::resp_byte(rec, lsr_pkg::SEL_BUTTONS)
                    + lsr_pkg::resp_byte(rec, lsr_pkg::SEL_P1_HI)
                    + lsr_pkg::resp_byte(rec, lsr_pkg::SEL_P1_LO)
                    + lsr_pkg::resp_byte(rec, lsr_pkg::SEL_P2_HI)
                    + lsr_pkg::resp_byte(rec, lsr_pkg::SEL_P2_LO);
        o_push_data = rec;
        o_push      = acc && (i_kind == lsr_pkg::KIND_RESPOND)
                          && (r_mode == lsr_pkg::MODE_RESP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= lsr_pkg::MODE_IDLE;
            r_fall_time <= 32'd0;
            r_break_min <= lsr_pkg::BREAK_MIN_RST;
            r_exp_pid   <= lsr_pkg::EXP_PID_RST;
        end else begin
            r_mode <= n_mode;
            if (acc && i_kind == lsr_pkg::KIND_FALL)
                r_fall_time <= i_line_time;
            if (i_cfg_valid) begin
                if (i_cfg_index == lsr_pkg::CFG_BREAK_MIN)
                    r_break_min <= i_cfg_data;
                if (i_cfg_index == lsr_pkg::CFG_EXP_PID)
                    r_exp_pid <= i_cfg_data[7:0];
            end
        end
    end

    // responding is only entered from a matching PID
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == lsr_pkg::MODE_RESP && $past(r_mode) != lsr_pkg::MODE_RESP)
        |-> $past(r_mode) == lsr_pkg::MODE_WAIT_PID)
        else $error("responding entered without PID match");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_q_stat.full)
        else $error("push into full queue");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_kind == lsr_pkg::KIND_SETTLE) |=> r_mode == lsr_pkg::MODE_IDLE)
        else $error("settle did not return to idle");

endmodule

// ===== hdl/lsr_fifo.sv =====
`timescale 1ns / 1ps

module lsr_fifo #(
    parameter int unsigned DEPTH = lsr_pkg::LSR_FIFO_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  lsr_pkg::t_resp   i_push_data,
    input  logic             i_pop,
    output lsr_pkg::t_resp   o_head,
    output lsr_pkg::t_q_stat o_stat
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    lsr_pkg::t_resp   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == CNT_FULL);
    assign o_stat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wr_ptr] <= i_push_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push)
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            if (i_pop)
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            if (i_push && !i_pop)
                r_count <= r_count + CNT_W'(1);
            else if (!i_push && i_pop)
                r_count <= r_count - CNT_W'(1);
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("queue count overflow");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("pop from empty queue");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("count did not follow push");

endmodule

// ===== hdl/lsr_back.sv =====
`timescale 1ns / 1ps

module lsr_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lsr_pkg::t_resp   i_head,
    input  lsr_pkg::t_q_stat i_q_stat,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [7:0]       o_tx_byte,
    output logic             o_last_byte
);

    lsr_pkg::t_bsel r_idx;
    logic           adv;
    logic           load;

    assign adv   = !o_out_valid || !i_out_stall;
    assign load  = adv && !i_q_stat.empty;
    assign o_pop = load && (r_idx == lsr_pkg::SEL_SUM);

    always_ff @(posedge i_clk) begin
        if (load) begin
            o_tx_byte   <= lsr_pkg::resp_byte(i_head, r_idx);
            o_last_byte <= (r_idx == lsr_pkg::SEL_SUM);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
            r_idx       <= lsr_pkg::SEL_BUTTONS;
        end else begin
            if (adv)
                o_out_valid <= !i_q_stat.empty;
            if (load)
                r_idx <= (r_idx == lsr_pkg::SEL_SUM) ? lsr_pkg::SEL_BUTTONS
                                                     : r_idx + 3'd1;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= lsr_pkg::SEL_SUM)
        else $error("byte index out of range");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_idx == lsr_pkg::SEL_BUTTONS && o_last_byte && o_out_valid))
        else $error("pop not aligned with checksum beat");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx != lsr_pkg::SEL_BUTTONS) |-> !i_q_stat.empty)
        else $error("frame in progress with empty queue");

endmodule

// ===== hdl/lin_slave_header_responder_core.sv =====
// A respond item is queued, then its first byte is registered onto o_tx_byte.
// Throughput: one input item per cycle while the response queue has room; the output
// side sends one byte per cycle while i_out_stall is low; each frame is six bytes.
// The queue holds FIFO_DEPTH frames; input stalls only when it is full.
// Reset (i_rst_n low, synchronous): idle mode, fall time zero, registers to defaults.
`timescale 1ns / 1ps

module lin_slave_header_responder_core #(
    parameter int unsigned FIFO_DEPTH = lsr_pkg::LSR_FIFO_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [2:0]                     i_kind,
    input  logic [31:0]                    i_line_time,
    input  logic [7:0]                     i_rx_byte,
    input  logic [6:0]                     i_buttons,
    input  logic [11:0]                    i_pot_one,
    input  logic [11:0]                    i_pot_two,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [lsr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [31:0]                    i_cfg_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [7:0]                     o_tx_byte,
    output logic                           o_last_byte
);

    lsr_pkg::t_q_stat q_stat;
    lsr_pkg::t_resp   push_data;
    lsr_pkg::t_resp   head;
    logic             push;
    logic             pop;

    assign o_cfg_ready = 1'b1;

    lsr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_kind      (i_kind),
        .i_line_time (i_line_time),
        .i_rx_byte   (i_rx_byte),
        .i_buttons   (i_buttons),
        .i_pot_one   (i_pot_one),
        .i_pot_two   (i_pot_two),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_stat    (q_stat),
        .o_push      (push),
        .o_push_data (push_data)
    );

    lsr_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_head      (head),
        .o_stat      (q_stat)
    );

    lsr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_q_stat    (q_stat),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_tx_byte   (o_tx_byte),
        .o_last_byte (o_last_byte)
    );

endmodule
